// ===== sv/lpms_pkg.sv =====
// Types and constants shared by the line-position and mode-select block.
// Holds the sensor weight table, the saturation limits and the yaw constants.
// No dependencies.
package lpms_pkg;

    localparam int unsigned NUM_SENSORS = 7;

    // Positions are in eighths of a unit.
    localparam logic signed [7:0] POS_SAT     = 8'sd80;
    localparam logic signed [7:0] POS_SAT_NEG = -8'sd80;
    localparam logic signed [7:0] POS_SNAP    = 8'sd64;
    localparam logic signed [7:0] POS_SNAP_NEG = -8'sd64;

    // Yaw in hundredths of a degree.
    localparam logic signed [17:0] HALF_TURN = 18'sd18000;
    localparam logic signed [17:0] FULL_TURN = 18'sd36000;
    localparam logic signed [15:0] YAW_MIN   = -16'sd18000;
    localparam logic signed [15:0] YAW_MAX   = 16'sd17999;

    typedef logic [6:0] hits_t;
    typedef logic signed [7:0] pos_t;
    typedef logic signed [15:0] yaw_t;

    // How many sensors see the line.
    typedef enum logic [1:0] {
        HITS_NONE,
        HITS_FEW,
        HITS_MANY
    } hit_class_t;

    // Result of the position unit for one sample.
    typedef struct packed {
        hit_class_t hit_class;
        pos_t       pos;
    } pos_result_t;

    // Sensor weight table in eighths: 9, 3, 1.25, 0, -1.25, -3, -9.
    function automatic pos_t sensor_weight(input logic [2:0] idx);
        pos_t w;
        begin
            unique case (idx)
                3'd0:    w = 8'sd72;
                3'd1:    w = 8'sd24;
                3'd2:    w = 8'sd10;
                3'd3:    w = 8'sd0;
                3'd4:    w = -8'sd10;
                3'd5:    w = -8'sd24;
                3'd6:    w = -8'sd72;
                default: w = 8'sd0;
            endcase
            return w;
        end
    endfunction

endpackage

// ===== sv/lpms_if.sv =====
// Request channel interfaces for the line-position and mode-select block.
// Sample channel in, result channel out; valid/ready handshake.
// Depends on lpms_pkg.
interface lpms_in_if
    import lpms_pkg::*;
();
    logic  valid;
    logic  ready;
    hits_t sensor_hits;
    logic  clear_guard;

    modport source (output valid, output sensor_hits, output clear_guard, input ready);
    modport sink   (input valid, input sensor_hits, input clear_guard, output ready);
endinterface

interface lpms_out_if
    import lpms_pkg::*;
();
    logic valid;
    logic ready;
    pos_t line_position;
    logic control_mode;
    yaw_t target_yaw;
    logic guard_active;

    modport source (output valid, output line_position, output control_mode,
                    output target_yaw, output guard_active, input ready);
    modport sink   (input valid, input line_position, input control_mode,
                    input target_yaw, input guard_active, output ready);
endinterface

// ===== sv/lpms_pos.sv =====
// Position unit: counts the hits, sums the weights and forms the new position.
// Pure combinational logic between the sample register and the state.
// Depends on lpms_pkg.
module lpms_pos
    import lpms_pkg::*;
(
    input  hits_t       hits,
    input  pos_t        pos_prev,
    output pos_result_t result
);

    logic [2:0]        count;
    logic signed [8:0] sum;
    logic signed [8:0] half;

    always_comb
    begin
        count = 3'd0;
        sum   = 9'sd0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (hits[i])
            begin
                count = count + 3'd1;
                sum   = sum + 9'(sensor_weight(3'(i)));
            end
        end
    end

    // Two hits always give an even sum, so the shift is exact.
    assign half = sum >>> 1;

    always_comb
    begin
        priority if (count == 3'd0)
        begin
            result.hit_class = HITS_NONE;
            // Snap a far-out held position to the rail.
            priority if (pos_prev >= POS_SNAP)
                result.pos = POS_SAT;
            else if (pos_prev <= POS_SNAP_NEG)
                result.pos = POS_SAT_NEG;
            else
                result.pos = pos_prev;
        end
        else if (count < 3'd3)
        begin
            result.hit_class = HITS_FEW;
            result.pos = (count == 3'd2) ? half[7:0] : sum[7:0];
        end
        else
        begin
            result.hit_class = HITS_MANY;
            result.pos = (sum > 9'sd0) ? POS_SAT : POS_SAT_NEG;
        end
    end

endmodule

// ===== sv/line_position_and_mode_select.sv =====
// Top level of the line-position and mode-select block.
// Instantiates lpms_pos; uses lpms_pkg and the channel interfaces in lpms_if.
//
// Use:
//   samples: one request per line-sensor sample (sensor_hits, clear_guard).
//   results: exactly one request per sample (line_position, control_mode,
//            target_yaw, guard_active), in sample order.
//   cfg_we / cfg_wdata: write the recorded yaw; write only while no sample
//            is in flight.
// Path: an accepted sample is registered in the sample register, processed
//   combinationally by lpms_pos and loaded into the state and result
//   registers, from which its result is offered until the receiver takes it.
// Throughput: one sample per cycle; the sample register and the result
//   register each turn over every cycle while results are taken.
// Reset: the position, mode, guard and yaw target clear, the lost parity
//   sets to odd, the recorded yaw clears, and both stages empty.
// Stall: when results.ready is low the result register holds; the sample
//   register still takes one more request, then samples.ready drops.
module line_position_and_mode_select
    import lpms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lpms_in_if.sink     samples,
    lpms_out_if.source  results,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    // Sample stage
    logic  s1_valid_reg;
    hits_t s1_hits_reg;
    logic  s1_clear_reg;

    // Result stage
    logic  out_valid_reg;

    // Block state
    yaw_t  rec_yaw_reg;
    pos_t  pos_reg,        pos_next;
    logic  mode_reg,       mode_next;
    logic  last_mode_reg,  last_mode_next;
    logic  guard_reg,      guard_next;
    logic  parity_reg,     parity_next;
    yaw_t  yaw_reg,        yaw_next;

    logic        out_load;
    logic        s1_load;
    logic        guard_eff;
    pos_result_t pos_res;
    logic signed [17:0] yaw_sum;
    logic signed [17:0] yaw_wrap;

    // Advance the result register when it is empty or being taken.
    assign out_load = s1_valid_reg && (!out_valid_reg || results.ready);
    assign s1_load  = samples.valid && samples.ready;
    assign samples.ready = !s1_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (samples.ready)
            s1_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_hits_reg  <= samples.sensor_hits;
            s1_clear_reg <= samples.clear_guard;
        end
    end

    lpms_pos u_pos (
        .hits     (s1_hits_reg),
        .pos_prev (pos_reg),
        .result   (pos_res)
    );

    // Clear the guard before the step.
    assign guard_eff = guard_reg && !s1_clear_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        mode_next      = mode_reg;
        last_mode_next = last_mode_reg;
        guard_next     = guard_eff;
        parity_next    = parity_reg;
        yaw_sum        = 18'(rec_yaw_reg);
        yaw_next       = yaw_reg;
        yaw_wrap       = 18'sd0;

        unique case (pos_res.hit_class)
            HITS_NONE:
            begin
                if (!guard_eff)
                begin
                    // Line lost: hand over to the gyro turn.
                    mode_next      = 1'b1;
                    last_mode_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_res.pos;
                end
            end
            HITS_FEW, HITS_MANY:
            begin
                pos_next  = pos_res.pos;
                mode_next = 1'b0;
                if (!guard_eff)
                begin
                    // Coming back from a gyro turn flips the parity and arms the guard.
                    if (last_mode_reg)
                    begin
                        parity_next    = !parity_reg;
                        last_mode_next = 1'b0;
                        guard_next     = 1'b1;
                    end
                    yaw_sum = 18'(rec_yaw_reg) + (parity_next ? HALF_TURN : 18'sd0)
                              + HALF_TURN;
                    // Range after the offset is within one turn either side.
                    priority if (yaw_sum < 18'sd0)
                        yaw_wrap = yaw_sum + FULL_TURN;
                    else if (yaw_sum >= FULL_TURN)
                        yaw_wrap = yaw_sum - FULL_TURN;
                    else
                        yaw_wrap = yaw_sum;
                    yaw_next = 16'(yaw_wrap - HALF_TURN);
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_yaw_reg   <= 16'sd0;
            pos_reg       <= 8'sd0;
            mode_reg      <= 1'b0;
            last_mode_reg <= 1'b0;
            guard_reg     <= 1'b0;
            parity_reg    <= 1'b1;
            yaw_reg       <= 16'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rec_yaw_reg <= cfg_wdata;
            if (out_load)
            begin
                pos_reg       <= pos_next;
                mode_reg      <= mode_next;
                last_mode_reg <= last_mode_next;
                guard_reg     <= guard_next;
                parity_reg    <= parity_next;
                yaw_reg       <= yaw_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result register mirrors the state after the last step.
    assign results.valid         = out_valid_reg;
    assign results.line_position = pos_reg;
    assign results.control_mode  = mode_reg;
    assign results.target_yaw    = yaw_reg;
    assign results.guard_active  = guard_reg;

    // Arming the guard always comes with a parity flip.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(guard_reg) |-> parity_reg != $past(parity_reg))
        else $error("guard armed without parity flip");

    // Gyro turn is only entered with the guard clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg |-> !guard_reg)
        else $error("gyro turn with guard set");

    // Target yaw stays wrapped.
    assert property (@(posedge clk) disable iff (!rst_n)
        yaw_reg >= YAW_MIN && yaw_reg <= YAW_MAX)
        else $error("target yaw out of range");

    // Position stays within the rails.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg >= POS_SAT_NEG && pos_reg <= POS_SAT)
        else $error("line position out of range");

endmodule
